FILE: sv/nmr_pkg.sv
package nmr_pkg;

   localparam int MAX_CORES       = 8;
   localparam int WORD_WIDTH      = 32;
   localparam int COUNT_WIDTH     = 16;
   localparam int CORE_IDX_WIDTH  = $clog2(MAX_CORES);
   localparam int CORE_NUM_WIDTH  = 4;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 4;
   localparam int STATUS_WIDTH    = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_NUM_CORES       = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MAJORITY_NEEDED = 2'd1;

   localparam logic [CORE_NUM_WIDTH-1:0] NUM_CORES_RESET = 4'd3;
   localparam logic [CORE_NUM_WIDTH-1:0] MAJORITY_RESET  = 4'd2;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK            = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_RECOVERABLE   = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_UNRECOVERABLE = 2'd2;

   localparam logic KIND_VOTE   = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   typedef logic [WORD_WIDTH-1:0] word_type;
   typedef word_type [MAX_CORES-1:0] word_array_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_VOTE,
      ST_SEND_VOTE,
      ST_SEND_REPORT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic vote;
      logic first_report;
      logic next_report;
      logic clear_round;
   } cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic last_word;
      logic last_report;
   } status_type;

endpackage

FILE: sv/nmr_datapath.sv
module nmr_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  nmr_pkg::cmd_type                       cmd,
   output nmr_pkg::status_type                    status,
   input  nmr_pkg::word_array_type                req_words,
   input  logic                                   req_last_word,
   input  logic                                   csr_we,
   input  logic [nmr_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [nmr_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata,
   output logic                                   rsp_report_kind,
   output logic [nmr_pkg::WORD_WIDTH-1:0]         rsp_voted_word,
   output logic                                   rsp_majority_found,
   output logic [nmr_pkg::CORE_IDX_WIDTH-1:0]     rsp_core_id,
   output logic [nmr_pkg::STATUS_WIDTH-1:0]       rsp_core_status,
   output logic [nmr_pkg::COUNT_WIDTH-1:0]        rsp_fault_count,
   output logic                                   rsp_last_result
);
   import nmr_pkg::*;

   logic [CORE_NUM_WIDTH-1:0] num_cores_ff, majority_ff;
   word_array_type            words_ff;
   logic                      last_ff;
   logic [COUNT_WIDTH-1:0]    cnt_ff [MAX_CORES];
   logic [COUNT_WIDTH-1:0]    cnt_in [MAX_CORES];
   logic                      failed_ff, failed_in;
   logic [CORE_IDX_WIDTH-1:0] idx_ff, idx_in;

   logic                      kind_ff, found_ff, rlast_ff;
   word_type                  voted_ff;
   logic [CORE_IDX_WIDTH-1:0] id_ff;
   logic [STATUS_WIDTH-1:0]   stat_ff;
   logic [COUNT_WIDTH-1:0]    errs_ff;

   logic [CORE_NUM_WIDTH-1:0] n_active;
   logic [CORE_IDX_WIDTH-1:0] n_last;
   logic [MAX_CORES-1:0]      active, ok;
   logic                      found;
   word_type                  voted;
   logic [STATUS_WIDTH-1:0]   rpt_status;
   logic [COUNT_WIDTH-1:0]    rpt_errs;

   // A core count of zero acts as one, anything above the maximum as the maximum.
   always_comb begin
      if (num_cores_ff == '0) begin
         n_active = CORE_NUM_WIDTH'(1);
      end else if (num_cores_ff > CORE_NUM_WIDTH'(MAX_CORES)) begin
         n_active = CORE_NUM_WIDTH'(MAX_CORES);
      end else begin
         n_active = num_cores_ff;
      end
      n_last = CORE_IDX_WIDTH'(n_active - CORE_NUM_WIDTH'(1));
   end

   always_comb begin
      logic [MAX_CORES-1:0]      same;
      logic [CORE_NUM_WIDTH-1:0] votes;
      same  = '0;
      votes = '0;
      for (int j = 0; j < MAX_CORES; j++) begin
         active[j] = CORE_NUM_WIDTH'(j) < n_active;
      end
      for (int j = 0; j < MAX_CORES; j++) begin
         for (int k = 0; k < MAX_CORES; k++) begin
            same[k] = active[k] && (words_ff[j] == words_ff[k]);
         end
         votes = CORE_NUM_WIDTH'($countones(same));
         ok[j] = active[j] && (votes >= majority_ff);
      end
      found = |ok;
      voted = '0;
      // The lowest core whose value reaches the threshold wins.
      for (int j = MAX_CORES - 1; j >= 0; j--) begin
         if (ok[j]) begin
            voted = words_ff[j];
         end
      end
   end

   always_comb begin
      failed_in = failed_ff;
      for (int j = 0; j < MAX_CORES; j++) begin
         cnt_in[j] = cnt_ff[j];
      end
      priority if (cmd.clear_round) begin
         failed_in = 1'b0;
         for (int j = 0; j < MAX_CORES; j++) begin
            cnt_in[j] = '0;
         end
      end else if (cmd.vote) begin
         if (!found) begin
            failed_in = 1'b1;
         end
         for (int j = 0; j < MAX_CORES; j++) begin
            if (found && active[j] && (words_ff[j] != voted) && (cnt_ff[j] != '1)) begin
               cnt_in[j] = cnt_ff[j] + COUNT_WIDTH'(1);
            end
         end
      end else begin
         failed_in = failed_ff;
      end
   end

   always_comb begin
      idx_in = cmd.first_report ? '0 : idx_ff + CORE_IDX_WIDTH'(1);
      if (failed_ff) begin
         rpt_status = STATUS_UNRECOVERABLE;
         rpt_errs   = '0;
      end else begin
         rpt_errs   = cnt_ff[idx_in];
         rpt_status = (rpt_errs != '0) ? STATUS_RECOVERABLE : STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_cores_ff <= NUM_CORES_RESET;
         majority_ff  <= MAJORITY_RESET;
         failed_ff    <= 1'b0;
         idx_ff       <= '0;
         for (int j = 0; j < MAX_CORES; j++) begin
            cnt_ff[j] <= '0;
         end
      end else begin
         if (csr_we && csr_index == REG_NUM_CORES) begin
            num_cores_ff <= csr_wdata;
         end
         if (csr_we && csr_index == REG_MAJORITY_NEEDED) begin
            majority_ff <= csr_wdata;
         end
         failed_ff <= failed_in;
         for (int j = 0; j < MAX_CORES; j++) begin
            cnt_ff[j] <= cnt_in[j];
         end
         if (cmd.first_report || cmd.next_report) begin
            idx_ff <= idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         words_ff <= req_words;
         last_ff  <= req_last_word;
      end
      if (cmd.vote) begin
         kind_ff  <= KIND_VOTE;
         voted_ff <= voted;
         found_ff <= found;
         id_ff    <= '0;
         stat_ff  <= STATUS_OK;
         errs_ff  <= '0;
         rlast_ff <= !last_ff;
      end else if (cmd.first_report || cmd.next_report) begin
         kind_ff  <= KIND_REPORT;
         voted_ff <= '0;
         found_ff <= 1'b0;
         id_ff    <= idx_in;
         stat_ff  <= rpt_status;
         errs_ff  <= rpt_errs;
         rlast_ff <= (idx_in == n_last);
      end
   end

   assign status.last_word   = last_ff;
   assign status.last_report = (idx_ff == n_last);

   assign rsp_report_kind    = kind_ff;
   assign rsp_voted_word     = voted_ff;
   assign rsp_majority_found = found_ff;
   assign rsp_core_id        = id_ff;
   assign rsp_core_status    = stat_ff;
   assign rsp_fault_count    = errs_ff;
   assign rsp_last_result    = rlast_ff;

endmodule

FILE: sv/nmr_ctrl.sv
module nmr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  nmr_pkg::status_type status,
   output nmr_pkg::cmd_type    cmd
);
   import nmr_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_VOTE;
            end
         end
         ST_VOTE: begin
            state_in = ST_SEND_VOTE;
         end
         ST_SEND_VOTE: begin
            if (rsp_ready) begin
               state_in = status.last_word ? ST_SEND_REPORT : ST_IDLE;
            end
         end
         ST_SEND_REPORT: begin
            if (rsp_ready && status.last_report) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_VOTE: begin
            cmd.vote = 1'b1;
         end
         ST_SEND_VOTE: begin
            rsp_valid        = 1'b1;
            cmd.first_report = rsp_ready && status.last_word;
         end
         ST_SEND_REPORT: begin
            rsp_valid       = 1'b1;
            cmd.next_report = rsp_ready && !status.last_report;
            cmd.clear_round = rsp_ready && status.last_report;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // The block never takes a request while a result is pending.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request accepted while a result is pending");

   a_vote_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (cmd.vote && !rsp_valid))
      else $error("vote did not follow an accepted request");

   a_result_after_vote: assert property (@(posedge clock) disable iff (reset)
      cmd.vote |=> (rsp_valid && !req_ready))
      else $error("voted result not presented after vote");

   a_round_end: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_round |=> (req_ready && !rsp_valid))
      else $error("block not idle after the final report");

endmodule

FILE: sv/nmr_majority_voter_top.sv
// N-modular-redundancy majority voter.
// Request channel (req_valid/req_ready): one word position from each of up to
// eight cores plus req_last_word, which closes a voting round.
// Response channel (rsp_valid/rsp_ready): one voted-word result per request,
// and after the last word of a round one report per active core, cores in
// ascending order. rsp_last_result marks the final response of a request.
// Configuration: csr_we with csr_index 0 sets the core count, index 1 the
// majority threshold. Write only while the block is idle.
// Timing: a request is captured into the word registers in the idle state,
// voted in the vote state, and its result is presented from the output
// register in the send state. The single shared comparator bank and output
// register serve one request at a time; a new request is taken once the final
// response is gone.
// Reset restores a core count of three and a threshold of two, and clears the
// mismatch counters and the round failure flag.
// When the receiver stalls, the response holds and no new request is taken.
module nmr_majority_voter_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [nmr_pkg::WORD_WIDTH-1:0]      req_word_core0,
   input  logic [nmr_pkg::WORD_WIDTH-1:0]      req_word_core1,
   input  logic [nmr_pkg::WORD_WIDTH-1:0]      req_word_core2,
   input  logic [nmr_pkg::WORD_WIDTH-1:0]      req_word_core3,
   input  logic [nmr_pkg::WORD_WIDTH-1:0]      req_word_core4,
   input  logic [nmr_pkg::WORD_WIDTH-1:0]      req_word_core5,
   input  logic [nmr_pkg::WORD_WIDTH-1:0]      req_word_core6,
   input  logic [nmr_pkg::WORD_WIDTH-1:0]      req_word_core7,
   input  logic                                req_last_word,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_report_kind,
   output logic [nmr_pkg::WORD_WIDTH-1:0]      rsp_voted_word,
   output logic                                rsp_majority_found,
   output logic [nmr_pkg::CORE_IDX_WIDTH-1:0]  rsp_core_id,
   output logic [nmr_pkg::STATUS_WIDTH-1:0]    rsp_core_status,
   output logic [nmr_pkg::COUNT_WIDTH-1:0]     rsp_fault_count,
   output logic                                rsp_last_result,
   input  logic                                csr_we,
   input  logic [nmr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [nmr_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import nmr_pkg::*;

   cmd_type        cmd;
   status_type     status;
   word_array_type req_words;

   assign req_words[0] = req_word_core0;
   assign req_words[1] = req_word_core1;
   assign req_words[2] = req_word_core2;
   assign req_words[3] = req_word_core3;
   assign req_words[4] = req_word_core4;
   assign req_words[5] = req_word_core5;
   assign req_words[6] = req_word_core6;
   assign req_words[7] = req_word_core7;

   nmr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   nmr_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_words          (req_words),
      .req_last_word      (req_last_word),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_report_kind    (rsp_report_kind),
      .rsp_voted_word     (rsp_voted_word),
      .rsp_majority_found (rsp_majority_found),
      .rsp_core_id        (rsp_core_id),
      .rsp_core_status    (rsp_core_status),
      .rsp_fault_count    (rsp_fault_count),
      .rsp_last_result    (rsp_last_result)
   );

endmodule
